>>> rtl/core/vpts_pkg.sv
// ----------------------------------------------------------------------------
// vpts_pkg: shared definitions for the vertex projection pipeline
// Field widths, register indexes and reset values used by the interfaces and
// by the top level.
// ----------------------------------------------------------------------------
package vpts_pkg;

	localparam int unsigned POINT_W  = 32;
	localparam int unsigned SCREEN_W = 24;
	localparam int unsigned ROW_W    = 64;
	localparam int unsigned VIEW_W   = 14;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_X  = 3'd0,
		CFG_ROW_Y  = 3'd1,
		CFG_ROW_W  = 3'd2,
		CFG_VIEW_W = 3'd3,
		CFG_VIEW_H = 3'd4
	} cfg_index_t;

	localparam logic [ROW_W-1:0]  ROW_X_RESET  = 64'h0000_0000_0000_0100;
	localparam logic [ROW_W-1:0]  ROW_Y_RESET  = 64'h0000_0000_0100_0000;
	localparam logic [ROW_W-1:0]  ROW_W_RESET  = 64'h0100_0000_0000_0000;
	localparam logic [VIEW_W-1:0] VIEW_W_RESET = 14'd640;
	localparam logic [VIEW_W-1:0] VIEW_H_RESET = 14'd480;

	localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 24'sh7FFFFF;
	localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = 24'sh800000;

endpackage

>>> rtl/core/vpts_point_if.sv
// ----------------------------------------------------------------------------
// vpts_point_if: input point channel
// Valid/ready channel that carries one world-space point per transfer.
// ----------------------------------------------------------------------------
interface vpts_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vpts_pkg::POINT_W-1:0] point_x;
	logic signed [vpts_pkg::POINT_W-1:0] point_y;
	logic signed [vpts_pkg::POINT_W-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

>>> rtl/core/vpts_screen_if.sv
// ----------------------------------------------------------------------------
// vpts_screen_if: screen position channel
// Valid/ready channel that carries one projected screen position per transfer.
// ----------------------------------------------------------------------------
interface vpts_screen_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vpts_pkg::SCREEN_W-1:0] screen_x;
	logic signed [vpts_pkg::SCREEN_W-1:0] screen_y;
	logic                                  w_invalid;

	modport source (output valid, output screen_x, output screen_y, output w_invalid,
		input ready);
	modport sink (input valid, input screen_x, input screen_y, input w_invalid,
		output ready);
endinterface

>>> rtl/core/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen: perspective projection and viewport mapping
// Projects a Q16.16 point through three matrix rows, divides by w and maps the
// result to Q16.8 screen coordinates with saturation.
// ----------------------------------------------------------------------------
// Usage:
// Points arrive on the "point" channel and screen positions leave on the
// "screen" channel; both are valid/ready, and a transfer happens on a rising
// clk edge with valid and ready high. One result leaves for every point.
// The block is a fully pipelined datapath: while the output is not stalled, a
// new point can be taken in every cycle, so throughput is one point per clock.
// A point passes through one product stage, three sum and scale stages, one
// stage to form the dividend, one range check and 23 restoring-division stages
// (one quotient bit each), then the output register.
// The division chain sets the latency.
// While the output register holds a result that the receiver has not taken,
// the whole pipeline freezes in place and the input ready drops, so nothing
// is dropped or repeated.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no points are in flight. An asynchronous reset
// empties the pipeline and loads the default matrix and a 640x480 viewport.
// ----------------------------------------------------------------------------
module vertex_project_to_screen (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vpts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vpts_pkg::ROW_W-1:0]       cfg_wdata,
	vpts_point_if.sink                       point,
	vpts_screen_if.source                    screen
);
	import vpts_pkg::*;

	localparam int unsigned QB = 23;  // quotient bits below the saturation limit

	// One lane of the long division (x or y).
	typedef struct packed {
		logic [47:0]   rem;
		logic [QB-1:0] ulow;
		logic [QB-1:0] q;
		logic          neg;
		logic          ovf;
	} div_lane_t;

	// ---------------- configuration registers ----------------
	logic [ROW_W-1:0]  row_x_q, row_y_q, row_w_q;
	logic [VIEW_W-1:0] view_w_q, view_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= ROW_X_RESET;
			row_y_q  <= ROW_Y_RESET;
			row_w_q  <= ROW_W_RESET;
			view_w_q <= VIEW_W_RESET;
			view_h_q <= VIEW_H_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_X:  row_x_q  <= cfg_wdata;
				CFG_ROW_Y:  row_y_q  <= cfg_wdata;
				CFG_ROW_W:  row_w_q  <= cfg_wdata;
				CFG_VIEW_W: view_w_q <= cfg_wdata[VIEW_W-1:0];
				CFG_VIEW_H: view_h_q <= cfg_wdata[VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [47:0] cmul(input logic [15:0] c,
		input logic signed [31:0] v);
		return 48'(signed'(c)) * 48'(v);
	endfunction

	function automatic logic signed [49:0] cterm(input logic [15:0] c);
		return 50'(signed'(c)) <<< 16;
	endfunction

	// The pipeline moves as a whole whenever the output register can take a
	// new value.
	logic out_valid_q;
	logic adv;
	assign adv         = !out_valid_q || screen.ready;
	assign point.ready = adv;

	// ---------------- stage 1: coefficient products ----------------
	logic                     v_s1;
	logic signed [47:0]       px_s1 [3];
	logic signed [47:0]       py_s1 [3];
	logic signed [47:0]       pw_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= point.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1[0] <= cmul(row_x_q[15:0],  point.point_x);
			px_s1[1] <= cmul(row_x_q[31:16], point.point_y);
			px_s1[2] <= cmul(row_x_q[47:32], point.point_z);
			py_s1[0] <= cmul(row_y_q[15:0],  point.point_x);
			py_s1[1] <= cmul(row_y_q[31:16], point.point_y);
			py_s1[2] <= cmul(row_y_q[47:32], point.point_z);
			pw_s1[0] <= cmul(row_w_q[15:0],  point.point_x);
			pw_s1[1] <= cmul(row_w_q[31:16], point.point_y);
			pw_s1[2] <= cmul(row_w_q[47:32], point.point_z);
		end
	end

	// ---------------- stage 2: homogeneous coordinates ----------------
	logic               v_s2;
	logic signed [49:0] hx_s2, hy_s2, hw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s2 <= 50'(px_s1[0]) + 50'(px_s1[1]) + 50'(px_s1[2]) + cterm(row_x_q[63:48]);
			hy_s2 <= 50'(py_s1[0]) + 50'(py_s1[1]) + 50'(py_s1[2]) + cterm(row_y_q[63:48]);
			hw_s2 <= 50'(pw_s1[0]) + 50'(pw_s1[1]) + 50'(pw_s1[2]) + cterm(row_w_q[63:48]);
		end
	end

	// ---------------- stage 3: numerators and divisor ----------------
	// Both screen formulas reduce to floor(num * size * 128 / hw).
	logic               v_s3, inv_s3;
	logic signed [49:0] nx_s3, ny_s3;
	logic [47:0]        den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3  <= hx_s2 + hw_s2;
			ny_s3  <= hw_s2 - hy_s2;
			den_s3 <= hw_s2[47:0];
			inv_s3 <= hw_s2[49] || (hw_s2 == '0);
		end
	end

	// ---------------- stage 4: scale by size*128 (split products) --------
	logic               v_s4, inv_s4;
	logic [47:0]        den_s4;
	logic [45:0]        xlo_s4, ylo_s4;
	logic signed [46:0] xhi_s4, yhi_s4;
	logic [20:0]        kx, ky;

	assign kx = {view_w_q, 7'd0};
	assign ky = {view_h_q, 7'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= den_s3;
			inv_s4 <= inv_s3;
			xlo_s4 <= 46'(nx_s3[24:0]) * 46'(kx);
			ylo_s4 <= 46'(ny_s3[24:0]) * 46'(ky);
			xhi_s4 <= 47'(signed'(nx_s3[49:25])) * 47'(signed'({1'b0, kx}));
			yhi_s4 <= 47'(signed'(ny_s3[49:25])) * 47'(signed'({1'b0, ky}));
		end
	end

	// ---------------- stage 5: dividend magnitude ----------------
	// For a negative dividend P, floor(P/d) equals the complement of
	// floor(~P/d), so the divider only ever sees a non-negative value.
	logic               v_s5, inv_s5;
	logic [47:0]        den_s5;
	logic [69:0]        ux_s5, uy_s5;
	logic               negx_s5, negy_s5;
	logic signed [70:0] prod_x, prod_y;

	assign prod_x = (71'(xhi_s4) <<< 25) + 71'(xlo_s4);
	assign prod_y = (71'(yhi_s4) <<< 25) + 71'(ylo_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s5  <= den_s4;
			inv_s5  <= inv_s4;
			negx_s5 <= prod_x[70];
			negy_s5 <= prod_y[70];
			ux_s5   <= prod_x[70] ? ~prod_x[69:0] : prod_x[69:0];
			uy_s5   <= prod_y[70] ? ~prod_y[69:0] : prod_y[69:0];
		end
	end

	// ---------------- division chain ----------------
	// Entry 0 holds the range check: a quotient of 2^23 or more saturates.
	// Each following entry resolves one quotient bit, most significant first.
	logic        dv_s   [QB+1];
	logic        dinv_s [QB+1];
	logic [47:0] dden_s [QB+1];
	div_lane_t   dx_s   [QB+1];
	div_lane_t   dy_s   [QB+1];

	function automatic div_lane_t div_start(input logic [69:0] u, input logic neg,
		input logic [47:0] den);
		div_lane_t l;
		l.ovf  = {1'b0, u[69:QB]} >= den;
		l.rem  = l.ovf ? '0 : {1'b0, u[69:QB]};
		l.ulow = u[QB-1:0];
		l.q    = '0;
		l.neg  = neg;
		return l;
	endfunction

	function automatic div_lane_t div_step(input div_lane_t a, input logic [47:0] den,
		input int unsigned bitpos);
		div_lane_t  l;
		logic [48:0] t;
		l = a;
		t = {a.rem, a.ulow[bitpos]};
		if (t >= {1'b0, den}) begin
			l.rem = 48'(t - {1'b0, den});
			l.q   = {a.q[QB-2:0], 1'b1};
		end else begin
			l.rem = t[47:0];
			l.q   = {a.q[QB-2:0], 1'b0};
		end
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else if (adv) dv_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dinv_s[0] <= inv_s5;
			dden_s[0] <= den_s5;
			dx_s[0]   <= div_start(ux_s5, negx_s5, den_s5);
			dy_s[0]   <= div_start(uy_s5, negy_s5, den_s5);
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[i+1] <= 1'b0;
			else if (adv) dv_s[i+1] <= dv_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dinv_s[i+1] <= dinv_s[i];
				dden_s[i+1] <= dden_s[i];
				dx_s[i+1]   <= div_step(dx_s[i], dden_s[i], QB - 1 - i);
				dy_s[i+1]   <= div_step(dy_s[i], dden_s[i], QB - 1 - i);
			end
		end
	end

	// ---------------- output register ----------------
	function automatic logic signed [SCREEN_W-1:0] finish(input div_lane_t l);
		logic signed [SCREEN_W-1:0] r;
		if (l.ovf) r = l.neg ? SCREEN_MIN : SCREEN_MAX;
		else       r = l.neg ? ~{1'b0, l.q} : {1'b0, l.q};
		return r;
	endfunction

	logic signed [SCREEN_W-1:0] sx_q, sy_q;
	logic                       inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= dv_s[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q <= dinv_s[QB];
			sx_q  <= dinv_s[QB] ? '0 : finish(dx_s[QB]);
			sy_q  <= dinv_s[QB] ? '0 : finish(dy_s[QB]);
		end
	end

	assign screen.valid     = out_valid_q;
	assign screen.screen_x  = sx_q;
	assign screen.screen_y  = sy_q;
	assign screen.w_invalid = inv_q;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for vertex_project_to_screen
// A queue-fed driver sends points in random bursts while the receiver stalls
// at random and once for a long stretch. Every accepted point is projected
// here with exact wide arithmetic, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
	import vpts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = 30;
	localparam int SETTLE     = LATENCY + 10;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 400;

	typedef struct packed {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic signed [POINT_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] sx;
		logic signed [SCREEN_W-1:0] sy;
		logic                       inv;
	} screen_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROW_W-1:0]   cfg_wdata;

	vpts_point_if  pt ();
	vpts_screen_if sc ();

	vertex_project_to_screen i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.point     (pt.sink),
		.screen    (sc.source)
	);

	always #4 clk = ~clk;

	// Our own copy of the matrix rows and the viewport, updated with every write.
	logic [ROW_W-1:0]  mat_x, mat_y, mat_w;
	logic [VIEW_W-1:0] vp_w, vp_h;

	point_t  points_to_send[$];
	screen_t screens_due[$];
	int      errors = 0;

	// Transfer flags, set at the rising edge; the falling-edge sender reads point_xfer.
	bit point_xfer, screen_xfer;

	// One row of the matrix times (x, y, z, 1.0); exact in 64 bits.
	function automatic longint row_dot(logic [ROW_W-1:0] row, point_t p);
		longint c0, c1, c2, c3;
		c0 = longint'($signed(row[15:0]));
		c1 = longint'($signed(row[31:16]));
		c2 = longint'($signed(row[47:32]));
		c3 = longint'($signed(row[63:48]));
		return c0 * longint'(p.x) + c1 * longint'(p.y) + c2 * longint'(p.z) + c3 * 65536;
	endfunction

	// floor(num * size * 128 / den) for den > 0, clamped to the screen range.
	// The product can exceed 64 bits, so the whole thing is done in 128.
	function automatic logic signed [SCREEN_W-1:0] viewport_scale(longint num, longint den,
			logic [VIEW_W-1:0] size);
		logic signed [127:0] prod, quo, dd, k;
		k = '0;
		k[20:0] = {size, 7'd0};
		prod = num;
		prod = prod * k;
		dd = den;
		quo = prod / dd;
		if ((prod % dd) != 0 && prod < 0)
			quo = quo - 1;
		if (quo > 128'sd8388607)
			return SCREEN_MAX;
		if (quo < -128'sd8388608)
			return SCREEN_MIN;
		return quo[SCREEN_W-1:0];
	endfunction

	function automatic screen_t project_point(point_t p);
		screen_t r;
		longint hx, hy, hw;
		hx = row_dot(mat_x, p);
		hy = row_dot(mat_y, p);
		hw = row_dot(mat_w, p);
		if (hw <= 0) begin
			r.sx = '0;
			r.sy = '0;
			r.inv = 1'b1;
		end else begin
			r.sx = viewport_scale(hx + hw, hw, vp_w);
			r.sy = viewport_scale(hw - hy, hw, vp_h);
			r.inv = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [31:0] small_coord();
		logic [31:0] m;
		m = $urandom_range(0, 1 << 19);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Most random points stay within a few units so that the projection lands on
	// screen; the rest use the full Q16.16 range and mostly saturate.
	function automatic point_t rand_point();
		point_t p;
		if ($urandom_range(0, 9) < 3) begin
			p.x = $urandom;
			p.y = $urandom;
			p.z = $urandom;
		end else begin
			p.x = small_coord();
			p.y = small_coord();
			p.z = small_coord();
		end
		return p;
	endfunction

	function automatic logic [15:0] rand_coeff(int span);
		logic [15:0] c;
		c = 16'($urandom_range(0, span));
		return $urandom_range(0, 1) ? -c : c;
	endfunction

	task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		points_to_send.push_back(p);
	endtask

	task automatic add_random(int n);
		repeat (n) points_to_send.push_back(rand_point());
	endtask

	// Wait until every point has gone through and the pipeline is surely empty.
	task automatic drain();
		wait (points_to_send.size() == 0 && screens_due.size() == 0 && pt.valid === 1'b0);
		repeat (SETTLE) @(posedge clk);
		wait (screens_due.size() == 0);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [ROW_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			CFG_ROW_X:  mat_x = v;
			CFG_ROW_Y:  mat_y = v;
			CFG_ROW_W:  mat_w = v;
			CFG_VIEW_W: vp_w  = v[VIEW_W-1:0];
			CFG_VIEW_H: vp_h  = v[VIEW_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry, logic [ROW_W-1:0] rw,
			int w, int h);
		write_reg(CFG_ROW_X, rx);
		write_reg(CFG_ROW_Y, ry);
		write_reg(CFG_ROW_W, rw);
		write_reg(CFG_VIEW_W, 64'(w));
		write_reg(CFG_VIEW_H, 64'(h));
	endtask

	// Stimulus and the final verdict.
	initial begin
		logic [ROW_W-1:0] rx, ry, rw;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pt.valid  = 1'b0;
		pt.point_x = '0;
		pt.point_y = '0;
		pt.point_z = '0;
		sc.ready  = 1'b0;
		mat_x = ROW_X_RESET;
		mat_y = ROW_Y_RESET;
		mat_w = ROW_W_RESET;
		vp_w  = VIEW_W_RESET;
		vp_h  = VIEW_H_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset matrix: w is always 1.0, so the input extremes show up directly
		// as saturation, and small negative x checks rounding toward minus infinity.
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		add_point(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000);
		add_point(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
		add_point(32'hFFFF_FFF3, 32'h0000_000B, 32'h0000_0000);
		add_point(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000);
		add_random(250);
		drain();

		// w taken from z alone: zero and negative w raise the invalid flag.
		// The viewport goes to its extreme sizes here.
		write_all(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
			64'h0000_0100_0000_0000, 8192, 1);
		add_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
		add_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
		add_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		add_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
		add_point(32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_random(250);
		drain();

		write_reg(CFG_VIEW_W, 64'd1);
		write_reg(CFG_VIEW_H, 64'd8192);
		add_random(150);
		drain();

		// Random moderate matrices with a positive w offset.
		repeat (4) begin
			rx = {rand_coeff(768), rand_coeff(768), rand_coeff(768), rand_coeff(768)};
			ry = {rand_coeff(768), rand_coeff(768), rand_coeff(768), rand_coeff(768)};
			rw = {16'($urandom_range(64, 1024)), rand_coeff(128), rand_coeff(128),
				rand_coeff(128)};
			write_all(rx, ry, rw, $urandom_range(1, 8192), $urandom_range(1, 8192));
			add_random(220);
			drain();
		end

		// Fully random rows so that every coefficient bit toggles.
		write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			$urandom_range(1, 8192), $urandom_range(1, 8192));
		add_random(150);
		drain();

		// Extreme coefficients.
		write_all(64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
			64'h7FFF_7FFF_7FFF_7FFF, 8192, 8192);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_random(120);
		drain();
		write_all(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
			64'h8000_0000_0000_8000, 1, 1);
		add_random(100);
		drain();

		if (errors == 0)
			$display("vertex_project_to_screen verification clean");
		else
			$display("vertex_project_to_screen verification failed");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		point_t p;
		if (arst_n && (!pt.valid || point_xfer)) begin
			if (gap_left > 0) begin
				pt.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (points_to_send.size() != 0) begin
				p = points_to_send.pop_front();
				pt.point_x <= p.x;
				pt.point_y <= p.y;
				pt.point_z <= p.z;
				pt.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pt.valid <= 1'b0;
			end
		end
	end

	// Receiver: alternates between stretches of random stalls and stretches that
	// take every result, and once holds off long enough to back up the pipeline.
	int rx_cycle = 0;
	int hold_left = 0;
	int mode_left = 0;
	bit stall_mode = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle == 1500) begin
				hold_left <= LONG_HOLD;
				sc.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				sc.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left <= $urandom_range(32, 256);
					stall_mode <= 1'($urandom_range(0, 1));
				end else begin
					mode_left <= mode_left - 1;
				end
				sc.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
			end
		end
	end

	// Monitor: predict on each point transfer, check on each screen transfer.
	always @(posedge clk) begin
		screen_t got, want;
		point_t p;
		point_xfer = arst_n && pt.valid && pt.ready;
		screen_xfer = arst_n && sc.valid && sc.ready;
		if (point_xfer) begin
			p.x = pt.point_x;
			p.y = pt.point_y;
			p.z = pt.point_z;
			screens_due.push_back(project_point(p));
		end
		if (screen_xfer) begin
			got.sx = sc.screen_x;
			got.sy = sc.screen_y;
			got.inv = sc.w_invalid;
			if (screens_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result sx=%0d sy=%0d w_invalid=%0b",
					$realtime, got.sx, got.sy, got.inv);
			end else begin
				want = screens_due.pop_front();
				if (got.sx !== want.sx) begin
					errors++;
					$display("%0t: screen_x expected %0d actual %0d", $realtime, want.sx, got.sx);
				end
				if (got.sy !== want.sy) begin
					errors++;
					$display("%0t: screen_y expected %0d actual %0d", $realtime, want.sy, got.sy);
				end
				if (got.inv !== want.inv) begin
					errors++;
					$display("%0t: w_invalid expected %0b actual %0b", $realtime,
						want.inv, got.inv);
				end
			end
		end
	end

	// Watchdog: too long without any transfer means the block has hung.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n && (pt.valid && pt.ready || sc.valid && sc.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
			$display("vertex_project_to_screen verification failed");
			$finish;
		end
	end

endmodule
